[rtl/dao_pkg.sv]
// Shared constants and types for the dual converter averager.
// No dependencies; every other file imports this package.
`default_nettype none
package dao_pkg;

  localparam int unsigned SampleBits = 10;
  localparam int unsigned CountW     = 4;
  localparam int unsigned SumW       = 14;
  localparam int unsigned FiltW      = 14;
  localparam int unsigned WideW      = 18;
  localparam int unsigned WeightLog  = 4;

  localparam logic [CountW-1:0] BlockLast = CountW'(15);

  localparam int unsigned NumW  = 13;
  localparam int unsigned ProdW = 27;
  localparam int unsigned QuotW = 13;
  localparam int unsigned RecipShift = 27;
  localparam int unsigned RecipW     = 13;
  localparam int unsigned EstW       = ProdW + RecipW;

  localparam logic [NumW-1:0]   ScaleNum = NumW'(7369);
  localparam logic [ProdW-1:0]  ScaleDen = ProdW'(20000);
  localparam logic [RecipW-1:0] RecipMul = RecipW'(6710);

  localparam int unsigned AddrW = 3;
  localparam int unsigned DataW = 32;
  localparam logic [AddrW-1:0] RegScaleAddr = AddrW'(0);

  typedef struct packed {
    logic en2;
    logic en3;
    logic en4;
  } dao_adv_t;

endpackage
`default_nettype wire

[rtl/dao_if.sv]
// Valid/ready channel interfaces for sample pairs and averaged results.
// Depends on dao_pkg.
`default_nettype none
interface dao_in_if import dao_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  first_done;
  logic [SampleBits-1:0] first_code;
  logic                  second_done;
  logic [SampleBits-1:0] second_code;

  modport source (output valid, first_done, first_code, second_done, second_code,
                  input ready);
  modport sink   (input valid, first_done, first_code, second_done, second_code,
                  output ready);
endinterface

interface dao_out_if import dao_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [FiltW-1:0] first_average;
  logic [FiltW-1:0] second_average;

  modport source (output valid, first_average, second_average, input ready);
  modport sink   (input valid, first_average, second_average, output ready);
endinterface
`default_nettype wire

[rtl/dual_adc_oversample_average_top.sv]
// Dual converter oversampling averager: input register, filter state update,
// three scaling stages to the result register. Depends on dao_pkg, dao_if,
// dao_accum and dao_scale.
//
// Takes one sample pair per cycle unless backpressure has filled every stage;
// each transfer in yields one result pair. A result passes through the
// input register, the filter state register and the three registered steps of
// the 7369/20000 scaling (product, reciprocal estimate, correction). Each
// stage holds its data under backpressure and empty stages fill, so the input
// stays ready while a result waits if a stage is still empty. The scale enable
// register is at byte address 0 and should only be written while the block is idle.
`default_nettype none
module dual_adc_oversample_average_top import dao_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  dao_in_if.sink                in_i,
  dao_out_if.source             out_o,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready
);

  logic scale_q;

  logic v0_q, v1_q, v2_q, v3_q, v4_q;
  logic rdy0, rdy1, rdy2, rdy3, rdy4;
  logic en0, en1;
  dao_adv_t adv;

  logic                  first_done_q, second_done_q;
  logic [SampleBits-1:0] first_code_q, second_code_q;
  logic [FiltW-1:0]      first_filt, second_filt;

  assign pready = 1'b1;
  assign prdata = (paddr == RegScaleAddr) ? DataW'(scale_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= 1'b0;
    end else if (psel && penable && pwrite && paddr == RegScaleAddr) begin
      scale_q <= pwdata[0];
    end
  end

  always_comb begin
    rdy4    = !v4_q || out_o.ready;
    rdy3    = !v3_q || rdy4;
    rdy2    = !v2_q || rdy3;
    rdy1    = !v1_q || rdy2;
    rdy0    = !v0_q || rdy1;
    en0     = in_i.valid && rdy0;
    en1     = v0_q && rdy1;
    adv.en2 = v1_q && rdy2;
    adv.en3 = v2_q && rdy3;
    adv.en4 = v3_q && rdy4;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy0) v0_q <= in_i.valid;
      if (rdy1) v1_q <= v0_q;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en0) begin
      first_done_q  <= in_i.first_done;
      first_code_q  <= in_i.first_code;
      second_done_q <= in_i.second_done;
      second_code_q <= in_i.second_code;
    end
  end

  assign in_i.ready  = rdy0;
  assign out_o.valid = v4_q;

  dao_accum u_first_accum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en1),
    .done_i (first_done_q),
    .code_i (first_code_q),
    .filt_o (first_filt)
  );

  dao_accum u_second_accum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en1),
    .done_i (second_done_q),
    .code_i (second_code_q),
    .filt_o (second_filt)
  );

  dao_scale u_first_scale (
    .clk_i      (clk_i),
    .adv_i      (adv),
    .scale_en_i (scale_q),
    .filt_i     (first_filt),
    .avg_o      (out_o.first_average)
  );

  dao_scale u_second_scale (
    .clk_i      (clk_i),
    .adv_i      (adv),
    .scale_en_i (scale_q),
    .filt_i     (second_filt),
    .avg_o      (out_o.second_average)
  );

endmodule
`default_nettype wire

[rtl/dao_accum.sv]
// One channel's block accumulator and exponential filter state.
// Depends on dao_pkg.
`default_nettype none
module dao_accum import dao_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  en_i,
  input  wire logic                  done_i,
  input  wire logic [SampleBits-1:0] code_i,
  output logic      [FiltW-1:0]      filt_o
);

  logic [CountW-1:0] count_q, count_d;
  logic [SumW-1:0]   sum_q, sum_d, sum_add;
  logic [FiltW-1:0]  filt_q, filt_d;
  logic [WideW-1:0]  mix;

  always_comb begin
    sum_add = sum_q + SumW'(code_i);
    mix     = (WideW'(filt_q) << WeightLog) - WideW'(filt_q) + WideW'(sum_add);
    count_d = count_q;
    sum_d   = sum_q;
    filt_d  = filt_q;
    if (en_i && done_i) begin
      if (count_q == BlockLast) begin
        count_d = '0;
        sum_d   = '0;
        filt_d  = mix[WeightLog +: FiltW];
      end else begin
        count_d = count_q + CountW'(1);
        sum_d   = sum_add;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      filt_q  <= '0;
    end else begin
      count_q <= count_d;
      sum_q   <= sum_d;
      filt_q  <= filt_d;
    end
  end

  assign filt_o = filt_q;

endmodule
`default_nettype wire

[rtl/dao_scale.sv]
// Three-stage optional scaling by 7369/20000 with truncation.
// Reciprocal estimate plus one correction step. Depends on dao_pkg.
`default_nettype none
module dao_scale import dao_pkg::*; (
  input  wire logic             clk_i,
  input  wire dao_adv_t         adv_i,
  input  wire logic             scale_en_i,
  input  wire logic [FiltW-1:0] filt_i,
  output logic      [FiltW-1:0] avg_o
);

  logic [FiltW-1:0] f2_q, f3_q;
  logic [ProdW-1:0] p2_q, p3_q;
  logic [QuotW-1:0] q3_q, q_fix;
  logic [EstW-1:0]  est;
  logic [ProdW-1:0] rem;
  logic [FiltW-1:0] avg_q;

  always_comb begin
    est   = EstW'(p2_q) * EstW'(RecipMul);
    rem   = p3_q - ProdW'(q3_q) * ScaleDen;
    q_fix = (rem >= ScaleDen) ? q3_q + QuotW'(1) : q3_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.en2) begin
      f2_q <= filt_i;
      p2_q <= ProdW'(filt_i) * ProdW'(ScaleNum);
    end
    if (adv_i.en3) begin
      f3_q <= f2_q;
      p3_q <= p2_q;
      q3_q <= est[RecipShift +: QuotW];
    end
    if (adv_i.en4) begin
      avg_q <= scale_en_i ? FiltW'(q_fix) : f3_q;
    end
  end

  assign avg_o = avg_q;

endmodule
`default_nettype wire
